/* hdl/dpid_pkg.sv */
package dpid_pkg;

	localparam int TEMP_W  = 12;
	localparam int ERR_W   = 13;
	localparam int COEF_W  = 16;
	localparam int ACC_W   = 16;
	localparam int DRIVE_W = 8;
	localparam int SUM_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [ACC_W-1:0]   ACC_MAX     = 16'd65280;
	localparam logic [DRIVE_W-1:0] DRIVE_FULL  = 8'd255;

	typedef enum logic [1:0] {
		MODE_HOLD = 2'd0,
		MODE_HEAT = 2'd1,
		MODE_COOL = 2'd2,
		MODE_OFF  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_HEAT_SP    = 3'd1,
		REG_COOL_SP    = 3'd2,
		REG_HEAT_NOW   = 3'd3,
		REG_HEAT_PREV  = 3'd4,
		REG_COOL_NOW   = 3'd5,
		REG_COOL_PREV  = 3'd6,
		REG_DERIV      = 3'd7
	} reg_idx_t;

	typedef logic signed [TEMP_W-1:0]  temp_t;
	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic [DRIVE_W-1:0]        drive_t;

	typedef struct packed {
		coef_t now;
		coef_t prev;
	} chan_coef_t;

	typedef struct packed {
		mode_t      mode;
		temp_t      heat_sp;
		temp_t      cool_sp;
		chan_coef_t heat_coef;
		chan_coef_t cool_coef;
		coef_t      deriv;
	} pid_cfg_t;

endpackage

/* hdl/dpid_if.sv */
interface dpid_in_if;
	logic                 valid;
	logic                 ready;
	dpid_pkg::temp_t      heater_temp;
	dpid_pkg::temp_t      cooler_temp;

	modport source (output valid, output heater_temp, output cooler_temp, input ready);
	modport sink   (input valid, input heater_temp, input cooler_temp, output ready);
endinterface

interface dpid_out_if;
	logic                 valid;
	logic                 ready;
	dpid_pkg::drive_t     heat_drive;
	dpid_pkg::drive_t     cool_drive;
	logic                 heat_relay_on;
	logic                 cool_relay_on;

	modport source (output valid, output heat_drive, output cool_drive,
		output heat_relay_on, output cool_relay_on, input ready);
	modport sink   (input valid, input heat_drive, input cool_drive,
		input heat_relay_on, input cool_relay_on, output ready);
endinterface

interface dpid_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [dpid_pkg::CFG_IDX_W-1:0]       index;
	logic [dpid_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/dpid_cfg.sv */
module dpid_cfg (
	input  logic               clk,
	input  logic               arst_n,
	dpid_cfg_if.sink           cfg,
	output dpid_pkg::pid_cfg_t regs
);
	import dpid_pkg::*;

	pid_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode           <= MODE_COOL;
			regs_q.heat_sp        <= 12'sd480;
			regs_q.cool_sp        <= 12'sd400;
			regs_q.heat_coef.now  <= 16'sd8400;
			regs_q.heat_coef.prev <= -16'sd8000;
			regs_q.cool_coef.now  <= 16'sd8400;
			regs_q.cool_coef.prev <= -16'sd8000;
			regs_q.deriv          <= '0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_MODE:      regs_q.mode           <= mode_t'(cfg.data[1:0]);
				REG_HEAT_SP:   regs_q.heat_sp        <= temp_t'(cfg.data[TEMP_W-1:0]);
				REG_COOL_SP:   regs_q.cool_sp        <= temp_t'(cfg.data[TEMP_W-1:0]);
				REG_HEAT_NOW:  regs_q.heat_coef.now  <= coef_t'(cfg.data);
				REG_HEAT_PREV: regs_q.heat_coef.prev <= coef_t'(cfg.data);
				REG_COOL_NOW:  regs_q.cool_coef.now  <= coef_t'(cfg.data);
				REG_COOL_PREV: regs_q.cool_coef.prev <= coef_t'(cfg.data);
				REG_DERIV:     regs_q.deriv          <= coef_t'(cfg.data);
				default: ;
			endcase
		end
	end

endmodule

/* hdl/dpid_chan.sv */
module dpid_chan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 run,
	input  dpid_pkg::err_t       err,
	input  dpid_pkg::chan_coef_t coef,
	input  dpid_pkg::coef_t      deriv,
	output dpid_pkg::drive_t     drive
);
	import dpid_pkg::*;

	logic [ACC_W-1:0]              accum_q;
	err_t                          err_last_q;
	err_t                          err_older_q;
	logic signed [COEF_W+ERR_W-1:0] p_now;
	logic signed [COEF_W+ERR_W-1:0] p_prev;
	logic signed [COEF_W+ERR_W-1:0] p_deriv;
	logic signed [SUM_W-1:0]        sum;
	logic [ACC_W-1:0]               accum_next;

	assign p_now   = coef.now  * err;
	assign p_prev  = coef.prev * err_last_q;
	assign p_deriv = deriv     * err_older_q;

	assign sum = $signed({{(SUM_W-ACC_W){1'b0}}, accum_q}) + SUM_W'(p_now)
		+ SUM_W'(p_prev) + SUM_W'(p_deriv);

	// clamp to the q8.8 range 0..255.0
	always_comb begin
		if (sum < 0)
			accum_next = '0;
		else if (sum > $signed({{(SUM_W-ACC_W){1'b0}}, ACC_MAX}))
			accum_next = ACC_MAX;
		else
			accum_next = sum[ACC_W-1:0];
	end

	assign drive = accum_next[ACC_W-1 -: DRIVE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			err_last_q  <= '0;
			err_older_q <= '0;
		end else if (run) begin
			accum_q     <= accum_next;
			err_older_q <= err_last_q;
			err_last_q  <= err;
		end
	end

endmodule

/* hdl/dual_incremental_pid_temp.sv */
// Two-zone incremental PID temperature controller.
// samples: one transfer per sampling tick, heater and cooler zone
//   temperatures as signed 1/16 degree values.
// results: one transfer per sample with both PWM drives and relay bits.
// cfg: register writes (index 0 mode, 1..2 setpoints, 3..7 gains), always
//   ready, only to be written while no sample is in flight.
// Mode heat updates the heater loop, mode cool the cooler loop, mode off
//   parks both drives at 255 with relays off, mode hold repeats the last
//   result unchanged.
// A sample is registered in the input register, then the three gain multiplies,
//   the sum and the clamp run combinationally into the result register,
//   which offers the result once the input register advances.
// Throughput: one sample per cycle unless results stalls; loop state is
//   rewritten with the result register, so the next sample sees it at once.
// A stalled result holds in its register while one more sample waits in
//   the input register; further samples are refused until results drains.
// Reset clears loop state, the last result (drives 0, relays off) and
//   loads the default mode and gains.
module dual_incremental_pid_temp (
	input  logic      clk,
	input  logic      arst_n,
	dpid_in_if.sink   samples,
	dpid_out_if.source results,
	dpid_cfg_if.sink  cfg
);
	import dpid_pkg::*;

	pid_cfg_t regs;

	logic   valid_s1;
	temp_t  heater_temp_s1;
	temp_t  cooler_temp_s1;

	logic   out_valid_q;
	drive_t heat_drive_q;
	drive_t cool_drive_q;
	logic   heat_relay_q;
	logic   cool_relay_q;

	logic   advance;
	logic   heat_run;
	logic   cool_run;
	err_t   heat_err;
	err_t   cool_err;
	drive_t heat_pid;
	drive_t cool_pid;

	dpid_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign advance       = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || advance;

	assign heat_run = advance && (regs.mode == MODE_HEAT);
	assign cool_run = advance && (regs.mode == MODE_COOL);

	assign heat_err = err_t'(heater_temp_s1) - err_t'(regs.heat_sp);
	assign cool_err = err_t'(regs.cool_sp) - err_t'(cooler_temp_s1);

	dpid_chan u_heat (
		.clk    (clk),
		.arst_n (arst_n),
		.run    (heat_run),
		.err    (heat_err),
		.coef   (regs.heat_coef),
		.deriv  (regs.deriv),
		.drive  (heat_pid)
	);

	dpid_chan u_cool (
		.clk    (clk),
		.arst_n (arst_n),
		.run    (cool_run),
		.err    (cool_err),
		.coef   (regs.cool_coef),
		.deriv  (regs.deriv),
		.drive  (cool_pid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			heater_temp_s1 <= samples.heater_temp;
			cooler_temp_s1 <= samples.cooler_temp;
		end
	end

	// result register doubles as the held outputs for hold mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			heat_drive_q <= '0;
			cool_drive_q <= '0;
			heat_relay_q <= 1'b0;
			cool_relay_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				case (regs.mode)
					MODE_HEAT: begin
						heat_drive_q <= heat_pid;
						cool_drive_q <= DRIVE_FULL;
						heat_relay_q <= 1'b1;
						cool_relay_q <= 1'b0;
					end
					MODE_COOL: begin
						heat_drive_q <= DRIVE_FULL;
						cool_drive_q <= cool_pid;
						heat_relay_q <= 1'b0;
						cool_relay_q <= 1'b1;
					end
					MODE_OFF: begin
						heat_drive_q <= DRIVE_FULL;
						cool_drive_q <= DRIVE_FULL;
						heat_relay_q <= 1'b0;
						cool_relay_q <= 1'b0;
					end
					default: ;
				endcase
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid         = out_valid_q;
	assign results.heat_drive    = heat_drive_q;
	assign results.cool_drive    = cool_drive_q;
	assign results.heat_relay_on = heat_relay_q;
	assign results.cool_relay_on = cool_relay_q;

endmodule
